// File: design/tsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants for timestamped sample playback
// operation codes, controller/datapath command and status words, saturation
// ----------------------------------------------------------------------------
package tsp_pkg;

    localparam int HISTORY_DEPTH_DEF = 8;
    localparam int TIME_W            = 32;
    localparam int POS_W             = 32;
    localparam int FRAC_W            = 16;
    localparam int DIV_CNT_W         = 4;
    localparam int SUM_W             = POS_W + 4;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_SEED  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture input word
        logic ring_upd;    // apply push / seed / clear
        logic walk_init;   // start walk at newest pair
        logic walk_dec;    // step walk one pair older
        logic rd_newer;    // read newer entry of pair (else older)
        logic cap_older;   // capture older entry from ram
        logic cap_newer;   // capture newer entry from ram
        logic setup;       // form elapsed, span, base, deltas
        logic frac_init;   // start fraction (clamp or divide)
        logic div_step;    // one quotient bit
        logic mul_x;       // x product
        logic mul_y;       // x sum, y product
        logic add_y;       // y sum
        logic res_zero;    // zero, invalid result
        logic res_newer;   // newer sample position as result
        logic out_load;    // move result to output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       few_held;
        logic       walk_more;
        logic       walk_later;
        logic       span_pos;
        logic       need_div;
        logic       div_last;
        logic       out_free;
    } t_sts;

    function automatic logic [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] max_v;
        logic signed [SUM_W-1:0] min_v;
        max_v = {{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
        min_v = {{(SUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};
        if (v > max_v) begin
            return max_v[POS_W-1:0];
        end else if (v < min_v) begin
            return min_v[POS_W-1:0];
        end
        return v[POS_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: design/timestamped_sample_playback.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timestamped_sample_playback: snapshot interpolation with bounded extrapolation
// push, seed, clear and a query on fewer than two samples go from dispatch
//   straight to the result hand-off; any other query also runs the bracket walk
//   (one pair at a time over the single ram read port) and, where the fraction
//   needs it, the restoring divider
// throughput: one word at a time; the next word is taken as soon as the
//   sequencer is back in idle, while the previous result may still wait
// reset (synchronous, active low) empties the history, clears the sequencer
//   and the output valid; the sample ram itself is not cleared
// ----------------------------------------------------------------------------
module timestamped_sample_playback #(
    parameter int HISTORY_DEPTH = tsp_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input word channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_operation,
    input  wire logic [tsp_pkg::TIME_W-1:0]         i_time_ms,
    input  wire logic signed [tsp_pkg::POS_W-1:0]   i_pos_x,
    input  wire logic signed [tsp_pkg::POS_W-1:0]   i_pos_y,
    // result word channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [tsp_pkg::POS_W-1:0]        o_out_x,
    output logic signed [tsp_pkg::POS_W-1:0]        o_out_y,
    output logic                                    o_valid_res
);

    // command and status between sequencer and datapath
    tsp_pkg::t_cmd cmd;
    tsp_pkg::t_sts sts;

    // sequencer: ring update, bracket walk, divide, two multiplies, hand-off
    tsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: sample ring in ram, pair registers, divider, multiplier,
    // saturating adders and the output register that decouples the result
    tsp_dpath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_operation (i_operation),
        .i_time_ms   (i_time_ms),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_valid_res (o_valid_res)
    );

endmodule
`default_nettype wire

// File: design/tsp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_ram: generic single-write, single-read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module tsp_ram #(
    parameter int WIDTH  = 96,
    parameter int DEPTH  = tsp_pkg::HISTORY_DEPTH_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: design/tsp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_ctrl: playback sequencer
// steps one word through ring update or query walk, divide and multiply
// ----------------------------------------------------------------------------
module tsp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire tsp_pkg::t_sts i_sts,
    output tsp_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK_RD,
        S_WALK_CHK,
        S_RD_OLD,
        S_RD_NEW,
        S_CAP_NEW,
        S_SETUP,
        S_FRAC,
        S_DIV,
        S_MUL_X,
        S_MUL_Y,
        S_ADD_Y,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.op != tsp_pkg::OP_QUERY) begin
                    o_cmd.ring_upd = 1'b1;
                    o_cmd.res_zero = 1'b1;
                    n_state        = S_FINISH;
                end else if (i_sts.few_held) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                if (i_sts.walk_more) begin
                    n_state = S_WALK_CHK;
                end else begin
                    n_state = S_RD_OLD;
                end
            end
            S_WALK_CHK: begin
                if (i_sts.walk_later) begin
                    o_cmd.walk_dec = 1'b1;
                    n_state        = S_WALK_RD;
                end else begin
                    n_state = S_RD_OLD;
                end
            end
            S_RD_OLD: begin
                n_state = S_RD_NEW;
            end
            S_RD_NEW: begin
                o_cmd.rd_newer  = 1'b1;
                o_cmd.cap_older = 1'b1;
                n_state         = S_CAP_NEW;
            end
            S_CAP_NEW: begin
                o_cmd.cap_newer = 1'b1;
                n_state         = S_SETUP;
            end
            S_SETUP: begin
                if (i_sts.span_pos) begin
                    o_cmd.setup = 1'b1;
                    n_state     = S_FRAC;
                end else begin
                    o_cmd.res_newer = 1'b1;
                    n_state         = S_FINISH;
                end
            end
            S_FRAC: begin
                o_cmd.frac_init = 1'b1;
                if (i_sts.need_div) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_MUL_X;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MUL_X;
                end
            end
            S_MUL_X: begin
                o_cmd.mul_x = 1'b1;
                n_state     = S_MUL_Y;
            end
            S_MUL_Y: begin
                o_cmd.mul_y = 1'b1;
                n_state     = S_ADD_Y;
            end
            S_ADD_Y: begin
                o_cmd.add_y = 1'b1;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: design/tsp_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_dpath: playback datapath
// sample ring, bracket walk, restoring divider, shared multiplier, output reg
// ----------------------------------------------------------------------------
module tsp_dpath #(
    parameter int HISTORY_DEPTH = tsp_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire tsp_pkg::t_cmd               i_cmd,
    output tsp_pkg::t_sts                    o_sts,
    input  wire logic [1:0]                  i_operation,
    input  wire logic [tsp_pkg::TIME_W-1:0]  i_time_ms,
    input  wire logic signed [tsp_pkg::POS_W-1:0] i_pos_x,
    input  wire logic signed [tsp_pkg::POS_W-1:0] i_pos_y,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic signed [tsp_pkg::POS_W-1:0] o_out_x,
    output logic signed [tsp_pkg::POS_W-1:0] o_out_y,
    output logic                             o_valid_res
);

    localparam int TW      = tsp_pkg::TIME_W;
    localparam int PW      = tsp_pkg::POS_W;
    localparam int FW      = tsp_pkg::FRAC_W;
    localparam int SW      = tsp_pkg::SUM_W;
    localparam int ENTRY_W = TW + 2 * PW;
    localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int AGE_SUM_W = CNT_W + 1;
    localparam int DW      = PW + 1;           // position delta
    localparam int PROD_W  = DW + FW + 2;      // delta times non-negative fraction
    localparam logic [AGE_SUM_W-1:0] DEPTH_EXT = AGE_SUM_W'(HISTORY_DEPTH);
    localparam logic [CNT_W-1:0]     DEPTH_CNT = CNT_W'(HISTORY_DEPTH);
    localparam logic [SLOT_W-1:0]    LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [FW:0]          FRAC_ONE  = {1'b1, {FW{1'b0}}};

    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] oldest,
                                                 input logic [CNT_W-1:0] age);
        logic [AGE_SUM_W-1:0] sum;
        sum = AGE_SUM_W'(oldest) + AGE_SUM_W'(age);
        if (sum >= DEPTH_EXT) begin
            sum = sum - DEPTH_EXT;
        end
        return sum[SLOT_W-1:0];
    endfunction

    // input word
    logic [1:0]           r_op;
    logic [TW-1:0]        r_t;
    logic signed [PW-1:0] r_px;
    logic signed [PW-1:0] r_py;

    // ring control
    logic [CNT_W-1:0]  r_held;
    logic [CNT_W-1:0]  n_held;
    logic [SLOT_W-1:0] r_oldest;
    logic [SLOT_W-1:0] n_oldest;
    logic [SLOT_W-1:0] wr_slot;
    logic              ram_we;

    // walk and bracketing pair
    logic [CNT_W-1:0]     r_b;
    logic [CNT_W-1:0]     rd_age;
    logic [SLOT_W-1:0]    rd_slot;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [TW-1:0]        rd_time;
    logic [TW-1:0]        r_tb;
    logic [TW-1:0]        r_ta;
    logic signed [PW-1:0] r_xb;
    logic signed [PW-1:0] r_yb;
    logic signed [PW-1:0] r_xa;
    logic signed [PW-1:0] r_ya;

    // blend
    logic                 past;
    logic                 before_pair;
    logic [TW-1:0]        r_num;
    logic [TW-1:0]        r_span;
    logic                 r_frac_zero;
    logic signed [PW-1:0] r_base_x;
    logic signed [PW-1:0] r_base_y;
    logic signed [DW-1:0] r_dx;
    logic signed [DW-1:0] r_dy;
    logic [FW:0]          r_frac;
    logic [TW-1:0]        r_rem;
    logic [tsp_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [TW:0]          rem2;
    logic signed [DW-1:0]   mul_a;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SW-1:0]   blend_sum_x;
    logic signed [SW-1:0]   blend_sum_y;

    // result and output
    logic [PW-1:0] r_res_x;
    logic [PW-1:0] r_res_y;
    logic          r_res_v;
    logic          r_out_valid;

    // ring update
    always_comb begin
        n_held   = r_held;
        n_oldest = r_oldest;
        wr_slot  = '0;
        ram_we   = 1'b0;
        case (r_op)
            tsp_pkg::OP_PUSH: begin
                ram_we = 1'b1;
                if (r_held >= DEPTH_CNT) begin
                    wr_slot  = r_oldest;
                    n_oldest = (r_oldest == LAST_SLOT) ? '0 : r_oldest + 1'b1;
                end else begin
                    wr_slot = slot_of(r_oldest, r_held);
                    n_held  = r_held + 1'b1;
                end
            end
            tsp_pkg::OP_SEED: begin
                ram_we   = 1'b1;
                wr_slot  = '0;
                n_held   = CNT_W'(1);
                n_oldest = '0;
            end
            tsp_pkg::OP_CLEAR: begin
                n_held   = '0;
                n_oldest = '0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign rd_age  = i_cmd.rd_newer ? r_b : r_b - 1'b1;
    assign rd_slot = slot_of(r_oldest, rd_age);

    tsp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we && i_cmd.ring_upd),
        .i_waddr (wr_slot),
        .i_wdata ({r_t, r_px, r_py}),
        .i_raddr (rd_slot),
        .o_rdata (ram_rdata)
    );

    assign rd_time     = ram_rdata[ENTRY_W-1 -: TW];
    assign past        = (r_ta <= r_t);
    assign before_pair = (r_t <= r_tb);
    assign rem2        = {r_rem, 1'b0};
    assign mul_a       = i_cmd.mul_y ? r_dy : r_dx;
    assign mul_p       = PROD_W'(mul_a) * signed'(PROD_W'({1'b0, r_frac}));
    assign blend_sum_x = SW'(r_base_x) + SW'($signed(r_prod[PROD_W-1:FW]));
    assign blend_sum_y = SW'(r_base_y) + SW'($signed(r_prod[PROD_W-1:FW]));

    always_comb begin
        o_sts            = '0;
        o_sts.op         = r_op;
        o_sts.few_held   = (r_held < CNT_W'(2));
        o_sts.walk_more  = (r_b > CNT_W'(1));
        o_sts.walk_later = (rd_time > r_t);
        o_sts.span_pos   = (r_ta > r_tb);
        o_sts.need_div   = !r_frac_zero && (r_num < r_span);
        o_sts.div_last   = (r_cnt == {tsp_pkg::DIV_CNT_W{1'b1}});
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_oldest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ring_upd) begin
                r_held   <= n_held;
                r_oldest <= n_oldest;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation;
            r_t  <= i_time_ms;
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
        if (i_cmd.walk_init) begin
            r_b <= r_held - 1'b1;
        end else if (i_cmd.walk_dec) begin
            r_b <= r_b - 1'b1;
        end
        if (i_cmd.cap_older) begin
            {r_tb, r_xb, r_yb} <= ram_rdata;
        end
        if (i_cmd.cap_newer) begin
            {r_ta, r_xa, r_ya} <= ram_rdata;
        end
        if (i_cmd.setup) begin
            r_num       <= past ? r_t - r_ta : r_t - r_tb;
            r_span      <= r_ta - r_tb;
            r_frac_zero <= !past && before_pair;
            r_base_x    <= past ? r_xa : r_xb;
            r_base_y    <= past ? r_ya : r_yb;
            r_dx        <= DW'(r_xa) - DW'(r_xb);
            r_dy        <= DW'(r_ya) - DW'(r_yb);
        end
        if (i_cmd.frac_init) begin
            r_rem <= r_num;
            r_cnt <= '0;
            if (r_frac_zero || r_num < r_span) begin
                r_frac <= '0;
            end else begin
                r_frac <= FRAC_ONE;
            end
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (rem2 >= {1'b0, r_span}) begin
                r_rem  <= TW'(rem2 - {1'b0, r_span});
                r_frac <= {r_frac[FW-1:0], 1'b1};
            end else begin
                r_rem  <= rem2[TW-1:0];
                r_frac <= {r_frac[FW-1:0], 1'b0};
            end
        end
        if (i_cmd.mul_x || i_cmd.mul_y) begin
            r_prod <= mul_p;
        end
        if (i_cmd.res_zero) begin
            r_res_x <= '0;
            r_res_y <= '0;
            r_res_v <= 1'b0;
        end else if (i_cmd.res_newer) begin
            r_res_x <= r_xa;
            r_res_y <= r_ya;
            r_res_v <= 1'b1;
        end else begin
            if (i_cmd.mul_y) begin
                r_res_x <= tsp_pkg::sat32(blend_sum_x);
            end
            if (i_cmd.add_y) begin
                r_res_y <= tsp_pkg::sat32(blend_sum_y);
                r_res_v <= 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            o_out_x     <= r_res_x;
            o_out_y     <= r_res_y;
            o_valid_res <= r_res_v;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire
